// File: sv/c5r_pkg.sv
package c5r_pkg;

    localparam int IMG_WIDTH    = 32;
    localparam int IMG_HEIGHT   = 32;
    localparam int OUT_CHANNELS = 6;
    localparam int KERNEL       = 5;

    localparam int PIX_W  = 16;
    localparam int ROW_W  = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
    localparam int COL_W  = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
    localparam int CH_W   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int KW_W   = (KERNEL > 1) ? $clog2(KERNEL) : 1;
    localparam int PROD_W = 2 * PIX_W;
    localparam int PART_W = PROD_W + KW_W;
    localparam int SUM_W  = PART_W + KW_W + 1;
    localparam int ACT_W  = 37;
    localparam int LINE_W = (KERNEL - 1) * PIX_W;
    localparam int COLV_W = KERNEL * PIX_W;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_PIXEL  = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [15:0] value;
    } item_t;

    typedef struct packed {
        logic [2:0]  channel;
        logic [4:0]  out_row;
        logic [4:0]  out_col;
        logic [36:0] activation;
        logic        last_of_run;
        logic        last_of_frame;
    } result_t;

    typedef struct packed {
        logic              en;
        logic [KW_W-1:0]   kh;
        logic [CH_W-1:0]   ch;
        logic [PIX_W-1:0]  value;
    } wr_t;

endpackage

// File: sv/c5r_ram.sv
module c5r_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/c5r_cell.sv
// One window column: holds KERNEL pixels, the weights of that kernel column
// for every channel, and forms the registered sum of its KERNEL products.
module c5r_cell (
    input  logic                                      clk,
    input  logic                                      shift_en,
    input  logic [c5r_pkg::COLV_W-1:0]                col_in,
    output logic [c5r_pkg::COLV_W-1:0]                col_out,
    input  c5r_pkg::wr_t                              wr,
    input  logic [c5r_pkg::CH_W-1:0]                  rd_ch,
    output logic signed [c5r_pkg::PART_W-1:0]         partial
);

    logic [c5r_pkg::COLV_W-1:0]        col_reg;
    logic [c5r_pkg::COLV_W-1:0]        col_next;
    logic signed [c5r_pkg::PART_W-1:0] partial_reg;
    logic signed [c5r_pkg::PART_W-1:0] partial_next;
    logic [c5r_pkg::PIX_W-1:0]         w_rd [c5r_pkg::KERNEL];
    logic signed [c5r_pkg::PROD_W-1:0] prod [c5r_pkg::KERNEL];

    for (genvar kh = 0; kh < c5r_pkg::KERNEL; kh++)
    begin : g_row
        c5r_ram #(
            .WIDTH (c5r_pkg::PIX_W),
            .DEPTH (c5r_pkg::OUT_CHANNELS)
        ) u_wram (
            .clk   (clk),
            .we    (wr.en && (wr.kh == c5r_pkg::KW_W'(kh))),
            .waddr (wr.ch),
            .wdata (wr.value),
            .raddr (rd_ch),
            .rdata (w_rd[kh])
        );
    end

    always_comb
    begin
        col_next = shift_en ? col_in : col_reg;
        partial_next = '0;
        for (int k = 0; k < c5r_pkg::KERNEL; k++)
        begin
            prod[k] = $signed(col_reg[k*c5r_pkg::PIX_W +: c5r_pkg::PIX_W])
                    * $signed(w_rd[k]);
            partial_next = partial_next + c5r_pkg::PART_W'(prod[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        partial_reg <= partial_next;
    end

    assign col_out = col_reg;
    assign partial = partial_reg;

endmodule

// File: sv/conv5x5_relu_stream_unit.sv
// Streaming 5x5 valid convolution with ReLU over a single-channel image.
// Input channel (item_valid / item_stall / item): each transaction carries a
// command and a signed Q8.8 value. Weights load in channel, row, column order,
// biases one per output channel, pixels in raster order. Load counters and
// the pixel position wrap on their own; command 3 is dropped.
// Output channel (result_valid / result_stall / result): for every pixel that
// completes a window, one transaction per output channel in ascending order,
// with the window position, the Q21.16 activation and end-of-run and
// end-of-frame marks.
// Weight, bias and edge pixels never hold the input themselves. A pixel
// that completes a window holds it during the line-buffer read and then
// while the six channels are issued in turn on the shared row of five
// column cells (25 multipliers); the next item can be taken while the last
// channel is issued. Each result is registered in the cells before the queue.
// Results go through a 16-entry output queue; a pixel that completes a window
// is taken only when the queue has room for all its results, so a stalled
// receiver backs up into item_stall without losing anything.
// Reset clears the counters, the pipeline and the queue; the stores hold
// whatever they held and must be loaded before use.
module conv5x5_relu_stream_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  c5r_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output c5r_pkg::result_t result
);

    localparam int K  = c5r_pkg::KERNEL;
    localparam int W  = c5r_pkg::PIX_W;
    localparam int OC = c5r_pkg::OUT_CHANNELS;

    // Input decode.
    logic item_acc;
    logic acc_weight;
    logic acc_bias;
    logic acc_pixel;
    logic pix_win;
    logic pix_frame_end;

    // Load and position counters.
    logic [c5r_pkg::KW_W-1:0]  wkw_reg, wkw_next;
    logic [c5r_pkg::KW_W-1:0]  wkh_reg, wkh_next;
    logic [c5r_pkg::CH_W-1:0]  wch_reg, wch_next;
    logic [c5r_pkg::CH_W-1:0]  bcnt_reg, bcnt_next;
    logic [c5r_pkg::ROW_W-1:0] prow_reg, prow_next;
    logic [c5r_pkg::COL_W-1:0] pcol_reg, pcol_next;

    logic [W-1:0] bias_reg [OC];

    // Stage 1: line-buffer read returns.
    logic                      s1_v_reg;
    logic                      s1_win_reg;
    logic [W-1:0]              s1_val_reg;
    logic [c5r_pkg::COL_W-1:0] s1_col_reg;
    logic [4:0]                s1_orow_reg;
    logic [4:0]                s1_ocol_reg;
    logic                      s1_fend_reg;
    logic [c5r_pkg::LINE_W-1:0] line_rd;
    logic [c5r_pkg::COLV_W-1:0] new_col;

    // Channel sequencer.
    logic                      run_reg, run_next;
    logic [c5r_pkg::CH_W-1:0]  ch_reg, ch_next;
    logic [4:0]                run_orow_reg;
    logic [4:0]                run_ocol_reg;
    logic                      run_fend_reg;
    logic                      run_last;

    // Product and sum stages.
    logic                      p1_v_reg;
    c5r_pkg::result_t          p1_meta_reg;
    logic [W-1:0]              p1_bias_reg;
    logic                      p2_v_reg;
    c5r_pkg::result_t          p2_meta_reg;
    logic [W-1:0]              p2_bias_reg;
    logic signed [c5r_pkg::SUM_W-1:0] sum;
    c5r_pkg::result_t          p2_res;

    logic signed [c5r_pkg::PART_W-1:0] partial [K];
    logic [c5r_pkg::COLV_W-1:0]        col_link [K];
    c5r_pkg::wr_t                      cell_wr [K];

    // Output queue.
    c5r_pkg::result_t            fifo_mem [c5r_pkg::FIFO_DEPTH];
    logic [c5r_pkg::FIFO_AW-1:0] wp_reg, rp_reg;
    logic [c5r_pkg::FIFO_AW:0]   cnt_reg, cnt_next;
    logic [c5r_pkg::FIFO_AW:0]   res_reg, res_next;
    logic                        pop;

    assign item_acc   = item_valid && !item_stall;
    assign acc_weight = item_acc && (item.cmd == c5r_pkg::CMD_WEIGHT);
    assign acc_bias   = item_acc && (item.cmd == c5r_pkg::CMD_BIAS);
    assign acc_pixel  = item_acc && (item.cmd == c5r_pkg::CMD_PIXEL);

    assign pix_win = (prow_reg >= c5r_pkg::ROW_W'(K - 1))
                  && (pcol_reg >= c5r_pkg::COL_W'(K - 1));
    assign pix_frame_end = (prow_reg == c5r_pkg::ROW_W'(c5r_pkg::IMG_HEIGHT - 1))
                        && (pcol_reg == c5r_pkg::COL_W'(c5r_pkg::IMG_WIDTH - 1));

    assign run_last = (ch_reg == c5r_pkg::CH_W'(OC - 1));

    // Hold off while a window is being formed or its channels are still being
    // issued, and while the queue cannot take a full run of results.
    assign item_stall = (s1_v_reg && s1_win_reg)
                     || (run_reg && !run_last)
                     || (res_reg > (c5r_pkg::FIFO_AW + 1)'(c5r_pkg::FIFO_DEPTH - OC));

    always_comb
    begin
        wkw_next  = wkw_reg;
        wkh_next  = wkh_reg;
        wch_next  = wch_reg;
        bcnt_next = bcnt_reg;
        prow_next = prow_reg;
        pcol_next = pcol_reg;
        if (acc_weight)
        begin
            if (wkw_reg == c5r_pkg::KW_W'(K - 1))
            begin
                wkw_next = '0;
                if (wkh_reg == c5r_pkg::KW_W'(K - 1))
                begin
                    wkh_next = '0;
                    wch_next = (wch_reg == c5r_pkg::CH_W'(OC - 1)) ? '0 : wch_reg + 1'b1;
                end
                else
                begin
                    wkh_next = wkh_reg + 1'b1;
                end
            end
            else
            begin
                wkw_next = wkw_reg + 1'b1;
            end
        end
        if (acc_bias)
        begin
            bcnt_next = (bcnt_reg == c5r_pkg::CH_W'(OC - 1)) ? '0 : bcnt_reg + 1'b1;
        end
        if (acc_pixel)
        begin
            if (pcol_reg == c5r_pkg::COL_W'(c5r_pkg::IMG_WIDTH - 1))
            begin
                pcol_next = '0;
                prow_next = (prow_reg == c5r_pkg::ROW_W'(c5r_pkg::IMG_HEIGHT - 1))
                          ? '0 : prow_reg + 1'b1;
            end
            else
            begin
                pcol_next = pcol_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wkw_reg  <= '0;
            wkh_reg  <= '0;
            wch_reg  <= '0;
            bcnt_reg <= '0;
            prow_reg <= '0;
            pcol_reg <= '0;
        end
        else
        begin
            wkw_reg  <= wkw_next;
            wkh_reg  <= wkh_next;
            wch_reg  <= wch_next;
            bcnt_reg <= bcnt_next;
            prow_reg <= prow_next;
            pcol_reg <= pcol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_bias)
        begin
            bias_reg[bcnt_reg] <= item.value;
        end
    end

    // Line buffer: one word per column holds the four rows above the current
    // one, newest in the low slice. Each pixel reads its column and writes it
    // back in the following cycle with every row moved up by one.
    c5r_ram #(
        .WIDTH (c5r_pkg::LINE_W),
        .DEPTH (c5r_pkg::IMG_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (s1_v_reg),
        .waddr (s1_col_reg),
        .wdata ({line_rd[c5r_pkg::LINE_W-W-1:0], s1_val_reg}),
        .raddr (pcol_reg),
        .rdata (line_rd)
    );

    always_comb
    begin
        new_col[(K-1)*W +: W] = s1_val_reg;
        for (int j = 0; j < K - 1; j++)
        begin
            new_col[j*W +: W] = line_rd[(K-2-j)*W +: W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= acc_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_pixel)
        begin
            s1_win_reg  <= pix_win;
            s1_val_reg  <= item.value;
            s1_col_reg  <= pcol_reg;
            s1_orow_reg <= 5'(prow_reg - c5r_pkg::ROW_W'(K - 1));
            s1_ocol_reg <= 5'(pcol_reg - c5r_pkg::COL_W'(K - 1));
            s1_fend_reg <= pix_frame_end;
        end
    end

    // Channel sequencer: one channel per cycle once the window is in place.
    always_comb
    begin
        run_next = run_reg;
        ch_next  = ch_reg;
        if (s1_v_reg && s1_win_reg)
        begin
            run_next = 1'b1;
            ch_next  = '0;
        end
        else if (run_reg)
        begin
            run_next = !run_last;
            ch_next  = run_last ? '0 : ch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            ch_reg   <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            ch_reg   <= ch_next;
            p1_v_reg <= run_reg;
            p2_v_reg <= p1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg && s1_win_reg)
        begin
            run_orow_reg <= s1_orow_reg;
            run_ocol_reg <= s1_ocol_reg;
            run_fend_reg <= s1_fend_reg;
        end
        p1_meta_reg.channel       <= 3'(ch_reg);
        p1_meta_reg.out_row       <= run_orow_reg;
        p1_meta_reg.out_col       <= run_ocol_reg;
        p1_meta_reg.activation    <= '0;
        p1_meta_reg.last_of_run   <= run_last;
        p1_meta_reg.last_of_frame <= run_last && run_fend_reg;
        p1_bias_reg               <= bias_reg[ch_reg];
        p2_meta_reg               <= p1_meta_reg;
        p2_bias_reg               <= p1_bias_reg;
    end

    // Row of column cells; the newest column enters at the right-hand cell
    // and every column moves one cell to the left on each pixel.
    for (genvar k = 0; k < K; k++)
    begin : g_cell
        always_comb
        begin
            cell_wr[k].en    = acc_weight && (wkw_reg == c5r_pkg::KW_W'(k));
            cell_wr[k].kh    = wkh_reg;
            cell_wr[k].ch    = wch_reg;
            cell_wr[k].value = item.value;
        end

        if (k == K - 1)
        begin : g_head
            c5r_cell u_cell (
                .clk      (clk),
                .shift_en (s1_v_reg),
                .col_in   (new_col),
                .col_out  (col_link[k]),
                .wr       (cell_wr[k]),
                .rd_ch    (ch_reg),
                .partial  (partial[k])
            );
        end
        else
        begin : g_body
            c5r_cell u_cell (
                .clk      (clk),
                .shift_en (s1_v_reg),
                .col_in   (col_link[k+1]),
                .col_out  (col_link[k]),
                .wr       (cell_wr[k]),
                .rd_ch    (ch_reg),
                .partial  (partial[k])
            );
        end
    end

    // Column partials plus the bias aligned to Q16.16, then ReLU.
    always_comb
    begin
        sum = c5r_pkg::SUM_W'($signed({p2_bias_reg, 8'b0}));
        for (int k = 0; k < K; k++)
        begin
            sum = sum + c5r_pkg::SUM_W'(partial[k]);
        end
        p2_res = p2_meta_reg;
        p2_res.activation = sum[c5r_pkg::SUM_W-1] ? '0 : sum[c5r_pkg::ACT_W-1:0];
    end

    // Output queue with a reservation count covering results still in flight.
    assign result_valid = (cnt_reg != '0);
    assign result       = fifo_mem[rp_reg];
    assign pop          = result_valid && !result_stall;

    always_comb
    begin
        cnt_next = cnt_reg + (c5r_pkg::FIFO_AW + 1)'(p2_v_reg)
                 - (c5r_pkg::FIFO_AW + 1)'(pop);
        res_next = res_reg - (c5r_pkg::FIFO_AW + 1)'(pop);
        if (acc_pixel && pix_win)
        begin
            res_next = res_next + (c5r_pkg::FIFO_AW + 1)'(OC);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (p2_v_reg)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg)
        begin
            fifo_mem[wp_reg] <= p2_res;
        end
    end

endmodule

// File: tb/sv/conv5x5_relu_stream_unit_checker.sv
module conv5x5_relu_stream_unit_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  c5r_pkg::item_t    item,
    input  logic              result_valid,
    input  logic              result_stall,
    input  c5r_pkg::result_t  result,
    output int                failures,
    output int                pending
);
    import c5r_pkg::*;

    localparam int NW = OUT_CHANNELS * KERNEL * KERNEL;

    logic signed [15:0] kernel_taps [NW];
    logic signed [15:0] channel_bias [OUT_CHANNELS];
    logic signed [15:0] rows_seen [KERNEL][IMG_WIDTH];
    int tap_idx;
    int bias_idx;
    int cur_row;
    int cur_col;
    result_t activations_due [$];

    initial failures = 0;
    initial pending = 0;

    // Model one accepted input transaction and queue the results it causes.
    task automatic absorb_item(input item_t it);
        longint acc;
        int orow;
        int ocol;
        result_t r;
        begin
            if (it.cmd == CMD_WEIGHT) begin
                kernel_taps[tap_idx] = it.value;
                tap_idx = (tap_idx + 1 >= NW) ? 0 : tap_idx + 1;
            end else if (it.cmd == CMD_BIAS) begin
                channel_bias[bias_idx] = it.value;
                bias_idx = (bias_idx + 1 >= OUT_CHANNELS) ? 0 : bias_idx + 1;
            end else if (it.cmd == CMD_PIXEL) begin
                rows_seen[cur_row % KERNEL][cur_col] = it.value;
                if (cur_row >= KERNEL - 1 && cur_col >= KERNEL - 1) begin
                    orow = cur_row - (KERNEL - 1);
                    ocol = cur_col - (KERNEL - 1);
                    for (int ch = 0; ch < OUT_CHANNELS; ch++) begin
                        acc = 0;
                        for (int kh = 0; kh < KERNEL; kh++)
                            for (int kw = 0; kw < KERNEL; kw++)
                                acc += longint'(rows_seen[(orow + kh) % KERNEL][ocol + kw])
                                     * longint'(kernel_taps[(ch * KERNEL + kh) * KERNEL + kw]);
                        acc += longint'(channel_bias[ch]) * 256;
                        if (acc < 0)
                            acc = 0;
                        r.channel = 3'(ch);
                        r.out_row = 5'(orow);
                        r.out_col = 5'(ocol);
                        r.activation = acc[36:0];
                        r.last_of_run = (ch == OUT_CHANNELS - 1);
                        r.last_of_frame = (ch == OUT_CHANNELS - 1) && cur_row == IMG_HEIGHT - 1
                                          && cur_col == IMG_WIDTH - 1;
                        activations_due.push_back(r);
                    end
                end
                if (cur_col + 1 >= IMG_WIDTH) begin
                    cur_col = 0;
                    cur_row = (cur_row + 1 >= IMG_HEIGHT) ? 0 : cur_row + 1;
                end else begin
                    cur_col = cur_col + 1;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tap_idx = 0;
            bias_idx = 0;
            cur_row = 0;
            cur_col = 0;
            activations_due.delete();
            pending = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (activations_due.size() == 0) begin
                    $display("%0t: unexpected result %p", $realtime, result);
                    failures++;
                end else if (result !== activations_due[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime,
                             activations_due[0], result);
                    failures++;
                    void'(activations_due.pop_front());
                end else begin
                    void'(activations_due.pop_front());
                end
            end
            if (item_valid && !item_stall)
                absorb_item(item);
            pending = activations_due.size();
        end
    end
endmodule

// File: tb/sv/conv5x5_relu_stream_unit_tb.sv
module conv5x5_relu_stream_unit_tb;
    import c5r_pkg::*;

    localparam int NW = OUT_CHANNELS * KERNEL * KERNEL;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;
    int      failures;
    int      pending;

    // When set, the receiver holds off for a long stretch so the output
    // queue fills and the block pushes back on its input.
    bit      long_hold;
    bit      stim_done;

    conv5x5_relu_stream_unit uut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    conv5x5_relu_stream_unit_checker chk (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one transaction after a random gap. Inputs change on the falling
    // edge; the transaction is done at the first rising edge without stall.
    task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] value);
        int gap;
        begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            repeat (gap)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
            end
            @(negedge clk);
            item_valid <= 1'b1;
            item.cmd <= cmd;
            item.value <= value;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
        end
    endtask

    // Draw a pixel or coefficient value, now and then at a field extreme.
    function automatic logic signed [15:0] draw_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_coefficients(input int mode);
        logic signed [15:0] v;
        begin
            for (int i = 0; i < NW; i++)
            begin
                v = (mode == 0) ? 16'sh7FFF : (mode == 1) ? 16'sh8000 : draw_value();
                send_item(CMD_WEIGHT, v);
            end
            for (int i = 0; i < OUT_CHANNELS; i++)
            begin
                v = (mode == 0) ? 16'sh7FFF : (mode == 1) ? 16'sh8000 : draw_value();
                send_item(CMD_BIAS, v);
            end
        end
    endtask

    // Receiver: a random stall length per result, with calm stretches, and
    // a long hold-off whenever the stimulus asks for one.
    initial
    begin
        int hold;
        result_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold) begin
                result_stall <= 1'b1;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold - 1) @(negedge clk);
                @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int idx;
        item_valid = 1'b0;
        item = '0;
        long_hold = 1'b0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Random taps and biases with extremes mixed in, then enough pixels
        // to complete the first window.
        load_coefficients(2);
        for (int p = 0; p < 4 * IMG_WIDTH + 5; p++)
            send_item(CMD_PIXEL, draw_value());
        // The ignored command changes nothing.
        send_item(2'd3, 16'sh7FFF);
        send_item(2'd3, 16'sh8000);
        // A bias reload mid-stream takes effect at once.
        for (int i = 0; i < OUT_CHANNELS; i++)
            send_item(CMD_BIAS, draw_value());
        for (int p = 0; p < 6; p++)
            send_item(CMD_PIXEL, 16'sh7FFF);
        // Pause until every expected result has come.
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        // Mixed traffic with a long receiver hold-off early on.
        idx = 0;
        while (idx < 40)
        begin
            if (idx == 5)
                long_hold = 1'b1;
            idx++;
            case ($urandom_range(0, 19))
                0: send_item(CMD_WEIGHT, draw_value());
                1: send_item(CMD_BIAS, draw_value());
                2: send_item(2'd3, 16'($urandom));
                default: send_item(CMD_PIXEL, draw_value());
            endcase
        end

        @(negedge clk);
        item_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// File: conv5x5_relu_stream_unit.f
sv/c5r_pkg.sv
sv/c5r_ram.sv
sv/c5r_cell.sv
sv/conv5x5_relu_stream_unit.sv
tb/sv/conv5x5_relu_stream_unit_checker.sv
tb/sv/conv5x5_relu_stream_unit_tb.sv
